FILE: sv/t0_procedure_byte_engine_macros.svh
// ----------------------------------------------------------------------------
// t0_procedure_byte_engine_macros
// Assertion macros for the T=0 procedure byte engine.
// ----------------------------------------------------------------------------
`ifndef T0_PROCEDURE_BYTE_ENGINE_MACROS_SVH
`define T0_PROCEDURE_BYTE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define T0PBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define T0PBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define T0PBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define T0PBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/t0pbe_pkg.sv
// ----------------------------------------------------------------------------
// t0pbe_pkg
// Types and constants shared by the T=0 procedure byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package t0pbe_pkg;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_PROC = 3'd1;
    localparam logic [2:0] PH_SW2  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_FAIL = 3'd4;

    localparam logic [2:0] ACT_WAIT   = 3'd0;
    localparam logic [2:0] ACT_TX     = 3'd1;
    localparam logic [2:0] ACT_STORED = 3'd2;
    localparam logic [2:0] ACT_DONE   = 3'd3;
    localparam logic [2:0] ACT_FAIL   = 3'd4;

    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_BYTE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic [7:0]  C_NULL_BYTE  = 8'h60;
    localparam logic [7:0]  C_HI_MASK    = 8'hF0;
    localparam logic [7:0]  C_SW1_6X     = 8'h60;
    localparam logic [7:0]  C_SW1_9X     = 8'h90;
    localparam logic [7:0]  C_ACK_MASK   = 8'hFE;
    localparam logic [15:0] C_NULL_LIMIT = 16'd800;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] null_total;
        logic [7:0]  saved_instruction;
        logic        sending_mode;
        logic [7:0]  send_remaining;
        logic [8:0]  room_remaining;
        logic [8:0]  bytes_stored;
        logic [8:0]  burst_remaining;
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] instruction;
        logic       to_card;
        logic [7:0] send_length;
        logic [8:0] receive_room;
        logic [7:0] card_byte;
    } t_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] transmit_count;
        logic [7:0] stored_byte;
        logic [8:0] stored_index;
        logic [8:0] response_length;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/t0_procedure_byte_engine.sv
// ----------------------------------------------------------------------------
// t0_procedure_byte_engine
// T=0 procedure byte handling: classifies card bytes of one exchange.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser is the kind (start, card byte, timeout,
//   none), tdata the header fields of a start and the card byte.
//   m_axis carries exactly one result per request: tuser is the action,
//   tdata the transmit count, stored byte, index and response length.
//   i_cfg_* writes the NULL byte limit; write it only while the block idles.
// Timing:
//   A result enters the output register when its request is taken. One
//   request per cycle is sustained without a stall; the state update of
//   one request is a single pass through the classifier before the next.
// Reset:
//   The exchange state returns to idle, the NULL limit to 800, the output
//   register empties. A failure locks the block until reset.
// Stall:
//   s_axis_tready drops only while the output register is full and
//   m_axis_tready is low; the waiting result then holds unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

`include "t0_procedure_byte_engine_macros.svh"

module t0_procedure_byte_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] instruction, [8] to_card, [16:9] send_length,
    // [25:17] receive_room, [33:26] card_byte, [39:34] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] transmit_count, [15:8] stored_byte, [24:16] stored_index,
    // [33:25] response_length, [39:34] zero
    output logic [39:0]      m_axis_tdata,
    // [2:0] action
    output logic [2:0]       m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import t0pbe_pkg::*;

    t_state     r_state;
    t_state     n_state;
    t_item      w_item;
    t_result    w_result;
    t_result    r_out;
    logic       r_out_valid;
    logic [15:0] r_null_limit;
    logic       w_accept;

    assign w_item.kind         = s_axis_tuser;
    assign w_item.instruction  = s_axis_tdata[7:0];
    assign w_item.to_card      = s_axis_tdata[8];
    assign w_item.send_length  = s_axis_tdata[16:9];
    assign w_item.receive_room = s_axis_tdata[25:17];
    assign w_item.card_byte    = s_axis_tdata[33:26];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    t0pbe_classify u_classify (
        .i_state      (r_state),
        .i_item       (w_item),
        .i_null_limit (r_null_limit),
        .o_state      (n_state),
        .o_result     (w_result)
    );

    // all-zero state is the idle phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_null_limit  <= C_NULL_LIMIT;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_null_limit <= i_cfg_data;
            end
            if (w_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tdata  = {6'd0, r_out.response_length, r_out.stored_index,
                            r_out.stored_byte, r_out.transmit_count};

    `T0PBE_ASSERT_NEXT(a_fail_locks, i_clk, i_rst_n,
        r_state.phase == PH_FAIL, r_state.phase == PH_FAIL,
        "failed phase left without reset")
    `T0PBE_ASSERT_NOW(a_fail_result_phase, i_clk, i_rst_n,
        r_out_valid && r_out.action == ACT_FAIL, r_state.phase == PH_FAIL,
        "fail result without locked phase")
    `T0PBE_ASSERT_NOW(a_no_overrun, i_clk, i_rst_n,
        w_accept, !r_out_valid || m_axis_tready,
        "request taken over a stalled result")
    `T0PBE_ASSERT_NOW(a_length_only_done, i_clk, i_rst_n,
        r_out_valid && r_out.action != ACT_DONE, r_out.response_length == 9'd0,
        "response length outside done")

endmodule

`default_nettype wire

FILE: sv/t0pbe_classify.sv
// ----------------------------------------------------------------------------
// t0pbe_classify
// Next exchange state and result for one request, from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module t0pbe_classify (
    input  wire t0pbe_pkg::t_state  i_state,
    input  wire t0pbe_pkg::t_item   i_item,
    input  wire logic [15:0]        i_null_limit,
    output t0pbe_pkg::t_state       o_state,
    output t0pbe_pkg::t_result      o_result
);
    import t0pbe_pkg::*;

    logic [7:0]  w_b;
    logic [16:0] w_null_next;
    logic        w_status;
    logic        w_all;
    logic        w_one;
    logic [8:0]  w_stored_next;

    assign w_b           = i_item.card_byte;
    assign w_null_next   = {1'b0, i_state.null_total} + 17'd1;
    assign w_status      = ((w_b & C_HI_MASK) == C_SW1_6X) ||
                           ((w_b & C_HI_MASK) == C_SW1_9X);
    assign w_all         = ((w_b ^ i_state.saved_instruction) & C_ACK_MASK) == 8'h00;
    assign w_one         = (((~w_b) ^ i_state.saved_instruction) & C_ACK_MASK) == 8'h00;
    assign w_stored_next = i_state.bytes_stored + 9'd1;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.action = ACT_WAIT;
        priority if (i_state.phase == PH_FAIL) begin
            o_result.action = ACT_FAIL;
        end else if (i_item.kind == KIND_NONE) begin
            o_result.action = ACT_WAIT;
        end else if (i_item.kind == KIND_START) begin
            if (i_state.phase != PH_IDLE) begin
                o_state.phase   = PH_FAIL;
                o_result.action = ACT_FAIL;
            end else begin
                o_state.saved_instruction = i_item.instruction;
                o_state.sending_mode      = i_item.to_card;
                o_state.send_remaining    = i_item.send_length;
                o_state.room_remaining    = i_item.receive_room;
                o_state.bytes_stored      = '0;
                o_state.null_total        = '0;
                o_state.burst_remaining   = '0;
                o_state.phase             = PH_PROC;
            end
        end else if (i_state.phase == PH_IDLE) begin
            o_result.action = ACT_WAIT;
        end else if (i_item.kind == KIND_TIMEOUT) begin
            o_state.phase   = PH_FAIL;
            o_result.action = ACT_FAIL;
        end else if (i_state.phase == PH_SW2) begin
            if (i_state.room_remaining == 9'd0) begin
                o_state.phase   = PH_FAIL;
                o_result.action = ACT_FAIL;
            end else begin
                o_state.bytes_stored     = w_stored_next;
                o_state.room_remaining   = i_state.room_remaining - 9'd1;
                o_state.phase            = PH_IDLE;
                o_result.action          = ACT_DONE;
                o_result.stored_byte     = w_b;
                o_result.stored_index    = i_state.bytes_stored;
                o_result.response_length = w_stored_next;
            end
        end else if (i_state.phase == PH_DATA) begin
            if (i_state.room_remaining == 9'd0) begin
                o_state.phase            = PH_IDLE;
                o_result.action          = ACT_DONE;
                o_result.response_length = i_state.bytes_stored;
            end else begin
                o_state.bytes_stored    = w_stored_next;
                o_state.room_remaining  = i_state.room_remaining - 9'd1;
                o_state.burst_remaining = i_state.burst_remaining - 9'd1;
                o_result.stored_byte    = w_b;
                o_result.stored_index   = i_state.bytes_stored;
                if (i_state.room_remaining == 9'd1) begin
                    o_state.phase            = PH_IDLE;
                    o_result.action          = ACT_DONE;
                    o_result.response_length = w_stored_next;
                end else begin
                    o_result.action = ACT_STORED;
                    if (i_state.burst_remaining == 9'd1) begin
                        o_state.phase = PH_PROC;
                    end
                end
            end
        end else if (w_b == C_NULL_BYTE) begin
            if (w_null_next > {1'b0, i_null_limit}) begin
                o_state.phase   = PH_FAIL;
                o_result.action = ACT_FAIL;
            end else begin
                o_state.null_total = w_null_next[15:0];
            end
        end else if (w_status) begin
            if (i_state.room_remaining == 9'd0) begin
                o_state.phase   = PH_FAIL;
                o_result.action = ACT_FAIL;
            end else begin
                o_state.bytes_stored   = w_stored_next;
                o_state.room_remaining = i_state.room_remaining - 9'd1;
                o_state.phase          = PH_SW2;
                o_result.action        = ACT_STORED;
                o_result.stored_byte   = w_b;
                o_result.stored_index  = i_state.bytes_stored;
            end
        end else if (!w_all && !w_one) begin
            o_state.phase   = PH_FAIL;
            o_result.action = ACT_FAIL;
        end else if (i_state.sending_mode) begin
            if (i_state.send_remaining == 8'd0) begin
                o_state.phase   = PH_FAIL;
                o_result.action = ACT_FAIL;
            end else begin
                o_result.action         = ACT_TX;
                o_result.transmit_count = w_all ? i_state.send_remaining : 8'd1;
                o_state.send_remaining  = w_all ? 8'd0 : i_state.send_remaining - 8'd1;
            end
        end else if (i_state.room_remaining == 9'd0) begin
            o_state.phase            = PH_IDLE;
            o_result.action          = ACT_DONE;
            o_result.response_length = i_state.bytes_stored;
        end else begin
            o_state.burst_remaining = w_all ? i_state.room_remaining : 9'd1;
            o_state.phase           = PH_DATA;
        end
    end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb - testbench for t0_procedure_byte_engine
// Drives start, card byte and timeout requests through the input stream. A
// scoreboard tracks the exchange state, predicts one result per accepted
// request and checks every result in order. Random exchanges run under
// several NULL limits and idle patterns. The run ends with one lockup and
// 30 random requests in the locked state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import t0pbe_pkg::*;

    class exchange_scoreboard;
        t_state      st;
        logic [15:0] null_limit;
        t_result     pending_results[$];
        int          mismatches;

        function new();
            st = '0;
            st.phase = PH_IDLE;
            null_limit = C_NULL_LIMIT;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function t_result lock();
            t_result r;
            r = '0;
            r.action = ACT_FAIL;
            st.phase = PH_FAIL;
            return r;
        endfunction

        function logic [8:0] store_byte();
            logic [8:0] idx;
            idx = st.bytes_stored;
            st.bytes_stored = st.bytes_stored + 9'd1;
            st.room_remaining = st.room_remaining - 9'd1;
            return idx;
        endfunction

        function t_result classify(t_item it);
            t_result     r;
            logic [7:0]  b;
            logic [16:0] n;
            logic [7:0]  tx;
            logic        all_ack;
            logic        one_ack;
            r = '0;
            r.action = ACT_WAIT;
            b = it.card_byte;
            if (st.phase == PH_FAIL) begin
                r.action = ACT_FAIL;
                return r;
            end
            if (it.kind == KIND_NONE) return r;
            if (it.kind == KIND_START) begin
                if (st.phase != PH_IDLE) return lock();
                st.saved_instruction = it.instruction;
                st.sending_mode = it.to_card;
                st.send_remaining = it.send_length;
                st.room_remaining = it.receive_room;
                st.bytes_stored = '0;
                st.null_total = '0;
                st.burst_remaining = '0;
                st.phase = PH_PROC;
                return r;
            end
            if (st.phase == PH_IDLE) return r;
            if (it.kind == KIND_TIMEOUT) return lock();

            if (st.phase == PH_SW2) begin
                if (st.room_remaining == 0) return lock();
                r.stored_index = store_byte();
                r.stored_byte = b;
                r.action = ACT_DONE;
                r.response_length = st.bytes_stored;
                st.phase = PH_IDLE;
                return r;
            end

            if (st.phase == PH_DATA) begin
                if (st.room_remaining == 0) begin
                    st.phase = PH_IDLE;
                    r.action = ACT_DONE;
                    r.response_length = st.bytes_stored;
                    return r;
                end
                r.stored_index = store_byte();
                r.stored_byte = b;
                st.burst_remaining = st.burst_remaining - 9'd1;
                if (st.room_remaining == 0) begin
                    st.phase = PH_IDLE;
                    r.action = ACT_DONE;
                    r.response_length = st.bytes_stored;
                    return r;
                end
                if (st.burst_remaining == 0) st.phase = PH_PROC;
                r.action = ACT_STORED;
                return r;
            end

            // procedure byte
            if (b == C_NULL_BYTE) begin
                n = {1'b0, st.null_total} + 17'd1;
                if (n > {1'b0, null_limit}) return lock();
                st.null_total = n[15:0];
                return r;
            end
            if ((b & C_HI_MASK) == C_SW1_6X || (b & C_HI_MASK) == C_SW1_9X) begin
                if (st.room_remaining == 0) return lock();
                r.stored_index = store_byte();
                r.stored_byte = b;
                r.action = ACT_STORED;
                st.phase = PH_SW2;
                return r;
            end
            all_ack = ((b ^ st.saved_instruction) & C_ACK_MASK) == 8'h00;
            one_ack = ((~b ^ st.saved_instruction) & C_ACK_MASK) == 8'h00;
            if (!all_ack && !one_ack) return lock();
            if (st.sending_mode) begin
                if (st.send_remaining == 0) return lock();
                tx = all_ack ? st.send_remaining : 8'd1;
                st.send_remaining = st.send_remaining - tx;
                r.action = ACT_TX;
                r.transmit_count = tx;
                return r;
            end
            if (st.room_remaining == 0) begin
                st.phase = PH_IDLE;
                r.action = ACT_DONE;
                r.response_length = st.bytes_stored;
                return r;
            end
            st.burst_remaining = all_ack ? st.room_remaining : 9'd1;
            st.phase = PH_DATA;
            return r;
        endfunction

        // outcome of a request without committing it
        function t_result peek(t_item it);
            t_state  keep;
            t_result r;
            keep = st;
            r = classify(it);
            st = keep;
            return r;
        endfunction

        function void note_request(t_item it);
            pending_results.push_back(classify(it));
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: action %0d", got.action);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("action", want.action, got.action);
            compare_field("transmit_count", want.transmit_count, got.transmit_count);
            compare_field("stored_byte", want.stored_byte, got.stored_byte);
            compare_field("stored_index", want.stored_index, got.stored_index);
            compare_field("response_length", want.response_length, got.response_length);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    exchange_scoreboard sb = new();
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_len = 0;

    t0_procedure_byte_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("t0_procedure_byte_engine verification failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        t_result r;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                r.action = m_axis_tuser;
                r.transmit_count = m_axis_tdata[7:0];
                r.stored_byte = m_axis_tdata[15:8];
                r.stored_index = m_axis_tdata[24:16];
                r.response_length = m_axis_tdata[33:25];
                sb.check_result(r);
            end
        end
    end

    function automatic t_item make_start(logic [7:0] ins, logic dir, logic [7:0] len,
                                         logic [8:0] room);
        t_item it;
        it = '0;
        it.kind = KIND_START;
        it.instruction = ins;
        it.to_card = dir;
        it.send_length = len;
        it.receive_room = room;
        return it;
    endfunction

    function automatic t_item make_byte(logic [7:0] b);
        t_item it;
        it = '0;
        it.kind = KIND_BYTE;
        it.card_byte = b;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it.kind = 2'($urandom_range(3));
        it.instruction = 8'($urandom_range(255));
        it.to_card = 1'($urandom_range(1));
        it.send_length = 8'($urandom_range(255));
        it.receive_room = 9'($urandom_range(258));
        it.card_byte = 8'($urandom_range(255));
        return it;
    endfunction

    function automatic t_item plan_request(bit wrap_up);
        t_item  it;
        t_state s;
        int     pick;
        logic   status_ins;
        s = sb.st;
        it = random_item();
        it.kind = KIND_BYTE;
        pick = $urandom_range(99);
        case (s.phase)
            PH_IDLE: begin
                if (pick < 85) begin
                    it.kind = KIND_START;
                    case ($urandom_range(19))
                        0, 1:    it.receive_room = 9'($urandom_range(258));
                        2:       it.receive_room = 9'($urandom_range(258, 250));
                        default: it.receive_room = 9'($urandom_range(12));
                    endcase
                    if ($urandom_range(4) != 0) it.send_length = 8'($urandom_range(8));
                    status_ins = (it.instruction[7:4] == 4'h6) || (it.instruction[7:4] == 4'h9);
                    // every ACK is a status byte then; keep room for SW1 and SW2
                    if ((it.to_card || status_ins) && it.receive_room < 2)
                        it.receive_room = 9'($urandom_range(8, 2));
                end else if (pick < 92) begin
                    it.kind = KIND_TIMEOUT;
                end else if (pick < 96) begin
                    it.kind = KIND_NONE;
                end
            end
            PH_PROC: begin
                if (wrap_up) pick = (s.room_remaining >= 2) ? 20 : 40;
                if (pick < 12) begin
                    it.card_byte = C_NULL_BYTE;
                end else if (pick < 30 && s.room_remaining >= 2) begin
                    it.card_byte = {(wrap_up || $urandom_range(1)) ? 4'h9 : 4'h6,
                                    4'($urandom_range(15))};
                end else if (pick < 55) begin
                    it.card_byte = {s.saved_instruction[7:1], 1'($urandom_range(1))};
                end else if (pick < 80) begin
                    it.card_byte = {~s.saved_instruction[7:1], 1'($urandom_range(1))};
                end else if (pick < 85) begin
                    it.kind = KIND_NONE;
                end
                // SW1 without room for SW2 would leave the exchange stuck
                if (s.room_remaining < 2 && it.card_byte != C_NULL_BYTE &&
                    ((it.card_byte & C_HI_MASK) == C_SW1_6X ||
                     (it.card_byte & C_HI_MASK) == C_SW1_9X))
                    it.card_byte = it.card_byte ^ 8'h80;
            end
            default: begin
                if (pick < 4 && !wrap_up) it.kind = KIND_NONE;
            end
        endcase
        return it;
    endfunction

    task automatic push_request(input t_item it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, it.card_byte, it.receive_room, it.send_length,
                         it.to_card, it.instruction};
        s_axis_tuser <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(it);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic write_limit(input logic [15:0] value);
        drain();
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.null_limit = value;
    endtask

    // random request that keeps the exchange alive
    task automatic offer_planned(input bit wrap_up);
        t_item   it;
        t_result outcome;
        int      tries;
        tries = 0;
        it = plan_request(wrap_up);
        outcome = sb.peek(it);
        while (outcome.action == ACT_FAIL && tries < 50) begin
            it = plan_request(wrap_up);
            outcome = sb.peek(it);
            tries++;
        end
        if (outcome.action == ACT_FAIL) it.kind = KIND_NONE;
        push_request(it);
    endtask

    task automatic provoke_lockup();
        int          which;
        logic [15:0] lim;
        which = $urandom_range(6);
        case (which)
            0: begin
                push_request(make_start(8'h20, 1'b0, 8'd3, 9'd6));
                push_request('{kind: KIND_TIMEOUT, default: '0});
            end
            1: begin
                push_request(make_start(8'h44, 1'b1, 8'd2, 9'd4));
                push_request(make_start(8'h44, 1'b0, 8'd0, 9'd2));
            end
            2: begin
                push_request(make_start(8'h00, 1'b0, 8'd0, 9'd4));
                push_request(make_byte(8'h20));
            end
            3: begin
                lim = 16'($urandom_range(3));
                write_limit(lim);
                push_request(make_start(8'h20, 1'b0, 8'd0, 9'd4));
                repeat (int'(lim) + 1) push_request(make_byte(C_NULL_BYTE));
            end
            4: begin
                push_request(make_start(8'h3C, 1'b1, 8'd0, 9'd2));
                push_request(make_byte(8'h3D));
            end
            5: begin
                push_request(make_start(8'h3C, 1'b0, 8'd0, 9'd0));
                push_request(make_byte(8'h9F));
            end
            default: begin
                push_request(make_start(8'h3C, 1'b1, 8'd3, 9'd1));
                push_request(make_byte(8'h6C));
                push_request(make_byte(8'($urandom_range(255))));
            end
        endcase
        repeat (30) begin
            push_request(random_item());
            maybe_gap();
        end
    endtask

    initial begin
        t_item       script[$];
        logic [15:0] lim;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= KIND_NONE;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_limit(16'd2);
        script.push_back('{kind: KIND_NONE, default: '0});
        script.push_back(make_byte(8'h55));
        script.push_back('{kind: KIND_TIMEOUT, default: '0});
        // send exchange: NULLs up to the limit, single and full ACK
        script.push_back(make_start(8'hA4, 1'b1, 8'd5, 9'd2));
        script.push_back(make_byte(C_NULL_BYTE));
        script.push_back(make_byte(C_NULL_BYTE));
        script.push_back(make_byte(8'h5B));
        script.push_back(make_byte(8'hA5));
        script.push_back(make_byte(8'h90));
        script.push_back(make_byte(8'h00));
        // receive exchange ending when the room fills
        script.push_back(make_start(8'hB0, 1'b0, 8'd0, 9'd3));
        script.push_back(make_byte(8'h4F));
        script.push_back(make_byte(8'hFF));
        script.push_back(make_byte(8'hB0));
        script.push_back(make_byte(8'h00));
        script.push_back(make_byte(8'h80));
        // ACK with no room for data
        script.push_back(make_start(8'h12, 1'b0, 8'd0, 9'd0));
        script.push_back(make_byte(8'h13));
        // INS that is also a status byte
        script.push_back(make_start(8'h61, 1'b0, 8'hFF, 9'd258));
        script.push_back(make_byte(8'h61));
        script.push_back(make_byte(8'h6F));
        script.push_back(make_start(8'hFF, 1'b1, 8'hFF, 9'd2));
        script.push_back(make_byte(8'hFE));
        script.push_back(make_byte(8'h6A));
        script.push_back(make_byte(8'h82));
        foreach (script[i]) push_request(script[i]);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    lim = 16'hFFFF;
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    lim = 16'h0000;
                    sender_idle_pct = 70;
                    recv_stall_pct = 0;
                end
                2: begin
                    lim = 16'($urandom_range(65535));
                    sender_idle_pct = 0;
                    recv_stall_pct = 70;
                end
                default: begin
                    lim = 16'($urandom_range(4, 1));
                    sender_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase
            write_limit(lim);
            for (int i = 0; i < 400; i++) begin
                offer_planned(1'b0);
                if (p == 0 && i == 200) hold_len = 80;
                if (p == 2 && i == 200) drain();
                else maybe_gap();
            end
            while (sb.st.phase != PH_IDLE) begin
                offer_planned(1'b1);
                maybe_gap();
            end
            drain();
        end

        provoke_lockup();
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("t0_procedure_byte_engine verification clean");
        end else begin
            $display("t0_procedure_byte_engine verification failed");
        end
        $finish;
    end

endmodule
